@@ sv/mbpm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbpm_pkg
// Shared constants, types and helpers of the masked byte pattern matcher.
// ----------------------------------------------------------------------------
package mbpm_pkg;

  // Sizing
  localparam int WINDOW_BYTES  = 8;   // bytes kept in the history window (1..8)
  localparam int OFFSET_BITS   = 32;  // width of the byte counter (16..48)
  localparam int BYTE_W        = 8;
  localparam int PATTERN_LANES = 8;   // pattern bytes held in the registers
  localparam int LEN_W         = 4;
  localparam int START_W       = 32;
  localparam int CFG_INDEX_W   = 2;
  localparam int CFG_DATA_W    = 64;

  // Register indexes on the configuration port
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_MASK      = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_LENGTH    = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_CASE_FOLD = 2'd3;

  // Uppercase range bounds and the case offset
  localparam logic [BYTE_W-1:0] UPPER_A    = 8'h41;
  localparam logic [BYTE_W-1:0] UPPER_Z    = 8'h5A;
  localparam logic [BYTE_W-1:0] CASE_DELTA = 8'h20;

  typedef logic [BYTE_W-1:0]                    byte_t;
  typedef logic [WINDOW_BYTES-1:0][BYTE_W-1:0]  window_t;
  typedef logic [OFFSET_BITS-1:0]               offset_t;
  typedef logic [LEN_W-1:0]                     len_t;

  localparam offset_t OFFSET_CAP = '1;

  // Configuration register set
  typedef struct packed {
    logic [CFG_DATA_W-1:0] pattern;
    logic [CFG_DATA_W-1:0] mask;
    len_t                  length;
    logic                  case_fold;
  } cfg_t;

  // One beat held in the input stage
  typedef struct packed {
    logic    valid;
    window_t window;
    offset_t offset;
    logic    last;
  } stage_t;

  // Map A-Z onto a-z, leave everything else alone
  function automatic byte_t fold_lower(input byte_t c);
    if (c >= UPPER_A && c <= UPPER_Z) begin
      return c + CASE_DELTA;
    end
    return c;
  endfunction

endpackage

@@ sv/masked_byte_pattern_matcher_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// masked_byte_pattern_matcher_unit
// Streaming masked byte-signature matcher, one result per input byte.
//
//   channel  dir  handshake            payload
//   input    in   in_valid/in_stall    data_byte, buffer_last
//   output   out  out_valid/out_stall  match_found, match_start, end_of_buffer
//   config   in   cfg_write            cfg_index, cfg_data
//
// One byte per cycle sustained while out_stall is low; a result is on the outputs
// once its byte has passed the input stage and then the result register.
// The window compare runs on all eight lanes in parallel.
// rst is synchronous: clears window, offset count and valids; resets config regs.
// A stalled output holds the result; one more byte waits in the input stage
// before in_stall rises.
// ----------------------------------------------------------------------------
module masked_byte_pattern_matcher_unit (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [7:0]                         data_byte,
  input  logic                               buffer_last,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               match_found,
  output logic [mbpm_pkg::START_W-1:0]       match_start,
  output logic                               end_of_buffer,
  input  logic                               cfg_write,
  input  logic [mbpm_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [mbpm_pkg::CFG_DATA_W-1:0]    cfg_data
);

  mbpm_pkg::cfg_t   cfg;
  mbpm_pkg::stage_t stage;
  logic             stage_take;

  // Configuration registers
  mbpm_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // History window, offset count and input stage
  mbpm_window u_window (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .data_byte   (data_byte),
    .buffer_last (buffer_last),
    .stage_take  (stage_take),
    .stage       (stage)
  );

  // Lane compare and result register
  mbpm_compare u_compare (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .stage         (stage),
    .stage_take    (stage_take),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .match_found   (match_found),
    .match_start   (match_start),
    .end_of_buffer (end_of_buffer)
  );

endmodule

@@ sv/mbpm_cfg_regs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbpm_cfg_regs
// Configuration register file: pattern, mask, length and case-fold mode.
// ----------------------------------------------------------------------------
module mbpm_cfg_regs (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [mbpm_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [mbpm_pkg::CFG_DATA_W-1:0]    cfg_data,
  output mbpm_pkg::cfg_t                     cfg
);

  mbpm_pkg::cfg_t regs;

  // Decode the index and update one register per write
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.pattern   <= '0;
      regs.mask      <= '1;
      regs.length    <= '0;
      regs.case_fold <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        mbpm_pkg::REG_PATTERN:   regs.pattern   <= cfg_data;
        mbpm_pkg::REG_MASK:      regs.mask      <= cfg_data;
        mbpm_pkg::REG_LENGTH:    regs.length    <= cfg_data[mbpm_pkg::LEN_W-1:0];
        mbpm_pkg::REG_CASE_FOLD: regs.case_fold <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign cfg = regs;

endmodule

@@ sv/mbpm_window.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbpm_window
// Byte history window, buffer offset counter and the input stage register.
// ----------------------------------------------------------------------------
module mbpm_window (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  mbpm_pkg::byte_t      data_byte,
  input  logic                 buffer_last,
  input  logic                 stage_take,
  output mbpm_pkg::stage_t     stage
);

  mbpm_pkg::window_t window;
  mbpm_pkg::offset_t count;
  mbpm_pkg::window_t window_next;
  mbpm_pkg::offset_t count_next;

  logic              stage_valid;
  mbpm_pkg::window_t stage_window;
  mbpm_pkg::offset_t stage_offset;
  logic              stage_last;
  logic              accept;

  // Hold the input while the stage is full and not draining
  assign in_stall = stage_valid && !stage_take;
  assign accept   = in_valid && !in_stall;

  // Shift the new byte in at the newest slot
  always_comb begin
    window_next[0] = data_byte;
    for (int j = 1; j < mbpm_pkg::WINDOW_BYTES; j++) begin
      window_next[j] = window[j-1];
    end
  end

  // Advance the offset, saturating at the top; restart from zero on a last beat
  always_comb begin
    if (buffer_last) begin
      count_next = '0;
    end else if (count != mbpm_pkg::OFFSET_CAP) begin
      count_next = count + 1'b1;
    end else begin
      count_next = count;
    end
  end

  // Window and count state; clear both after the last beat of a buffer
  always_ff @(posedge clk) begin
    if (rst) begin
      window <= '0;
      count  <= '0;
    end else if (accept) begin
      window <= buffer_last ? '0 : window_next;
      count  <= count_next;
    end
  end

  // Input stage: capture the shifted window and the offset of this beat
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (accept) begin
      stage_valid <= 1'b1;
    end else if (stage_take) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stage_window <= window_next;
      stage_offset <= count;
      stage_last   <= buffer_last;
    end
  end

  assign stage.valid  = stage_valid;
  assign stage.window = stage_window;
  assign stage.offset = stage_offset;
  assign stage.last   = stage_last;

  // A closed buffer restarts counting from zero
  a_count_clear: assert property (@(posedge clk) disable iff (rst)
    accept && buffer_last |=> count == '0)
    else $error("offset count not cleared after last beat");

  // Offset steps by one within a buffer until it saturates
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    accept && !buffer_last && count != mbpm_pkg::OFFSET_CAP |=>
      count == $past(count) + 1'b1)
    else $error("offset count did not advance");

endmodule

@@ sv/mbpm_compare.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbpm_compare
// Parallel lane compare of the window against the pattern and result register.
// ----------------------------------------------------------------------------
module mbpm_compare (
  input  logic                           clk,
  input  logic                           rst,
  input  mbpm_pkg::cfg_t                 cfg,
  input  mbpm_pkg::stage_t               stage,
  output logic                           stage_take,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           match_found,
  output logic [mbpm_pkg::START_W-1:0]   match_start,
  output logic                           end_of_buffer
);

  localparam int WIDE_W = (mbpm_pkg::OFFSET_BITS > mbpm_pkg::START_W) ?
                          mbpm_pkg::OFFSET_BITS : mbpm_pkg::START_W;
  localparam mbpm_pkg::len_t WIN_LEN = mbpm_pkg::LEN_W'(mbpm_pkg::WINDOW_BYTES);

  mbpm_pkg::byte_t [mbpm_pkg::PATTERN_LANES-1:0] lane_byte;
  logic [mbpm_pkg::PATTERN_LANES-1:0]            lane_hit;
  mbpm_pkg::len_t                                span;
  mbpm_pkg::offset_t                             span_wide;
  mbpm_pkg::offset_t                             start_off;
  logic                                          len_ok;
  logic                                          reach;
  logic                                          found;
  logic [mbpm_pkg::START_W-1:0]                  start_next;
  logic                                          out_free;

  // Pattern spans len bytes ending at the newest window slot
  assign span      = cfg.length - 1'b1;
  assign span_wide = {{(mbpm_pkg::OFFSET_BITS - mbpm_pkg::LEN_W){1'b0}}, span};
  assign len_ok    = (cfg.length != '0) && (cfg.length <= WIN_LEN);
  assign reach     = stage.offset >= span_wide;

  // Compare each pattern lane with the window byte it lines up with
  always_comb begin
    for (int i = 0; i < mbpm_pkg::PATTERN_LANES; i++) begin
      lane_byte[i] = '0;
      for (int j = 0; j < mbpm_pkg::WINDOW_BYTES; j++) begin
        if (mbpm_pkg::LEN_W'(j) == span - mbpm_pkg::LEN_W'(i)) begin
          lane_byte[i] = stage.window[j];
        end
      end
      if (mbpm_pkg::LEN_W'(i) >= cfg.length) begin
        lane_hit[i] = 1'b1;
      end else if (cfg.case_fold) begin
        lane_hit[i] = mbpm_pkg::fold_lower(lane_byte[i]) ==
                      mbpm_pkg::fold_lower(cfg.pattern[8*i +: 8]);
      end else begin
        lane_hit[i] = (cfg.mask[8*i +: 8] & lane_byte[i]) == cfg.pattern[8*i +: 8];
      end
    end
  end

  assign found     = len_ok && reach && (&lane_hit);
  assign start_off = stage.offset - span_wide;

  // Report the start offset only on a hit
  always_comb begin
    if (found) begin
      start_next = WIDE_W'(start_off) >> 0;
    end else begin
      start_next = '0;
    end
  end

  // Result register: refill whenever it is empty or being taken
  assign out_free   = !out_valid || !out_stall;
  assign stage_take = stage.valid && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= stage.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_take) begin
      match_found   <= found;
      match_start   <= start_next;
      end_of_buffer <= stage.last;
    end
  end

  // A beat leaving the stage lands in the result register
  a_take_lands: assert property (@(posedge clk) disable iff (rst)
    stage_take |=> out_valid)
    else $error("stage beat lost on its way to the result register");

  // No offset is reported without a match
  a_start_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !match_found |-> match_start == '0)
    else $error("nonzero start offset on a miss");

  // End-of-buffer flag follows its beat
  a_last_carry: assert property (@(posedge clk) disable iff (rst)
    stage_take && stage.last |=> end_of_buffer)
    else $error("end-of-buffer flag dropped");

endmodule
